// File: rtl/ihw_pkg.sv
// Shared types, register indexes and character constants of the Intel HEX record writer.
`timescale 1ns / 1ps
`default_nettype none

package ihw_pkg;

    localparam int JOB_DEPTH_DEFAULT = 4;

    localparam logic [1:0] REG_BYTES_PER_ROW = 2'd0;
    localparam logic [1:0] REG_HEX_MODE      = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS  = 2'd2;
    localparam logic [1:0] REG_EXPORT_LENGTH = 2'd3;

    localparam logic [1:0] MODE_I8  = 2'd0;
    localparam logic [1:0] MODE_I16 = 2'd1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [7:0]  DEFAULT_ROW = 8'd16;
    localparam logic [16:0] PAGE_SIZE   = 17'h10000;
    localparam logic [31:0] SEG_LIMIT   = 32'h0010FFF0;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_SEG  = 8'h02;
    localparam logic [7:0] REC_LIN  = 8'h04;
    localparam logic [7:0] EXT_LEN  = 8'h02;
    localparam logic [7:0] EOF_CS   = 8'hFF;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_of_run;
        logic       overrun;
    } out_t;

    typedef struct packed {
        logic [7:0]  bytes_per_row;
        logic [1:0]  hex_mode;
        logic [31:0] base_address;
        logic [31:0] export_length;
    } cfg_t;

    typedef struct packed {
        logic        ovr;
        logic        ext;
        logic        ext_seg;
        logic [15:0] ext_val;
        logic [7:0]  ext_cs;
        logic        hdr;
        logic [7:0]  rec_len;
        logic [15:0] rec_addr;
        logic        dat;
        logic [7:0]  data;
        logic        trl;
        logic [7:0]  trl_cs;
        logic        eof;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/ihw_front.sv
// Front end: accepts commands and data bytes, tracks the export position and builds record jobs.
`timescale 1ns / 1ps
`default_nettype none

module ihw_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire ihw_pkg::in_t   item,
    input  wire ihw_pkg::cfg_t  cfg,
    output logic                job_push,
    output ihw_pkg::job_t       job
);

    logic [31:0] next_addr_reg, next_addr_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [7:0]  rec_left_reg, rec_left_next;
    logic [7:0]  csum_reg, csum_next;
    logic        use_seg_reg, use_seg_next;
    logic        active_reg, active_next;
    logic        page_pending_reg, page_pending_next;

    logic [16:0] dist_page;
    logic [16:0] span;
    logic [7:0]  per_row;
    logic [7:0]  rem;
    logic        new_rec;
    logic [7:0]  rec_left_eff;
    logic [7:0]  rec_left_after;
    logic [7:0]  csum_base;
    logic [7:0]  csum_after;
    logic [7:0]  ext_type;
    logic [15:0] ext_val;

    always_comb
    begin
        dist_page = ihw_pkg::PAGE_SIZE - {1'b0, next_addr_reg[15:0]};
        span = (remaining_reg < {15'd0, dist_page}) ? remaining_reg[16:0] : dist_page;
        per_row = (cfg.bytes_per_row == 8'd0) ? ihw_pkg::DEFAULT_ROW : cfg.bytes_per_row;
        rem = (span < {9'd0, per_row}) ? span[7:0] : per_row;
        new_rec = (rec_left_reg == 8'd0);
        rec_left_eff = new_rec ? rem : rec_left_reg;
        rec_left_after = rec_left_eff - 8'd1;
        csum_base = new_rec ? (rem + next_addr_reg[15:8] + next_addr_reg[7:0]) : csum_reg;
        csum_after = csum_base + item.data_byte;
        ext_type = use_seg_reg ? ihw_pkg::REC_SEG : ihw_pkg::REC_LIN;
        ext_val = use_seg_reg ? next_addr_reg[19:4] : next_addr_reg[31:16];

        next_addr_next = next_addr_reg;
        remaining_next = remaining_reg;
        rec_left_next = rec_left_reg;
        csum_next = csum_reg;
        use_seg_next = use_seg_reg;
        active_next = active_reg;
        page_pending_next = page_pending_reg;
        job = '0;
        job_push = 1'b0;

        if (accept)
        begin
            if (item.cmd == ihw_pkg::CMD_START)
            begin
                next_addr_next = cfg.base_address;
                remaining_next = cfg.export_length;
                rec_left_next = 8'd0;
                csum_next = 8'd0;
                use_seg_next = (cfg.hex_mode == ihw_pkg::MODE_I16)
                    && (cfg.export_length < ihw_pkg::SEG_LIMIT);
                active_next = (cfg.export_length != 32'd0);
                page_pending_next = (cfg.export_length != 32'd0);
                job.eof = (cfg.export_length == 32'd0);
                job_push = (cfg.export_length == 32'd0);
            end
            else if (!active_reg)
            begin
                job.ovr = 1'b1;
                job_push = 1'b1;
            end
            else
            begin
                job_push = 1'b1;
                if (new_rec)
                begin
                    if (page_pending_reg || (next_addr_reg[15:0] == 16'd0))
                    begin
                        job.ext = (cfg.hex_mode != ihw_pkg::MODE_I8);
                        page_pending_next = 1'b0;
                    end
                    job.hdr = 1'b1;
                end
                job.ext_seg = use_seg_reg;
                job.ext_val = ext_val;
                job.ext_cs = 8'd0 - (ihw_pkg::EXT_LEN + ext_type + ext_val[15:8] + ext_val[7:0]);
                job.rec_len = rem;
                job.rec_addr = next_addr_reg[15:0];
                job.dat = 1'b1;
                job.data = item.data_byte;
                job.trl = (rec_left_after == 8'd0);
                job.trl_cs = 8'd0 - csum_after;
                job.eof = (remaining_reg == 32'd1);
                next_addr_next = next_addr_reg + 32'd1;
                remaining_next = remaining_reg - 32'd1;
                rec_left_next = rec_left_after;
                csum_next = csum_after;
                active_next = (remaining_reg != 32'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_addr_reg <= '0;
            remaining_reg <= '0;
            rec_left_reg <= '0;
            csum_reg <= '0;
            use_seg_reg <= 1'b0;
            active_reg <= 1'b0;
            page_pending_reg <= 1'b0;
        end
        else
        begin
            next_addr_reg <= next_addr_next;
            remaining_reg <= remaining_next;
            rec_left_reg <= rec_left_next;
            csum_reg <= csum_next;
            use_seg_reg <= use_seg_next;
            active_reg <= active_next;
            page_pending_reg <= page_pending_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihw_job_fifo.sv
// Short queue of record jobs between the front end and the character sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ihw_job_fifo #(
    parameter int DEPTH = ihw_pkg::JOB_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire ihw_pkg::job_t  wr_job,
    input  wire logic           rd_en,
    output ihw_pkg::job_t       rd_job,
    output logic                full,
    output logic                nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ihw_pkg::job_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ihw_back.sv
// Back end: walks each record job and sends its text one character per beat.
`timescale 1ns / 1ps
`default_nettype none

module ihw_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_avail,
    input  wire ihw_pkg::job_t  job_head,
    output logic                job_take,
    input  wire logic           pop,
    output logic                empty,
    output ihw_pkg::out_t       result
);

    typedef enum logic [2:0] {
        PH_OVR,
        PH_EXT,
        PH_HDR,
        PH_DAT,
        PH_TRL,
        PH_EOF
    } phase_t;

    phase_t          phase_reg;
    phase_t          next_ph;
    logic [3:0]      idx_reg;
    logic            busy_reg;
    ihw_pkg::job_t   job_reg;
    logic            out_valid_reg;
    ihw_pkg::out_t   out_reg;

    logic            adv;
    logic            phase_last;
    logic            job_done;
    logic            has_colon;
    logic            has_nl;
    logic [2:0]      nbytes;
    logic [3:0]      len_m1;
    logic [3:0]      h;
    logic [7:0]      b;
    logic [3:0]      nib;
    logic [7:0]      ch;

    function automatic phase_t first_phase(input ihw_pkg::job_t j);
        phase_t p;
        if (j.ovr)
        begin
            p = PH_OVR;
        end
        else if (j.ext)
        begin
            p = PH_EXT;
        end
        else if (j.hdr)
        begin
            p = PH_HDR;
        end
        else if (j.dat)
        begin
            p = PH_DAT;
        end
        else
        begin
            p = PH_EOF;
        end
        return p;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = ihw_pkg::CHAR_ZERO + {4'd0, v};
        end
        else
        begin
            c = ihw_pkg::CHAR_A + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

    assign empty = !out_valid_reg;
    assign result = out_reg;
    assign adv = busy_reg && (!out_valid_reg || pop);

    always_comb
    begin
        has_colon = 1'b0;
        has_nl = 1'b0;
        nbytes = 3'd0;
        len_m1 = 4'd0;
        next_ph = PH_EOF;
        job_done = 1'b1;
        b = 8'd0;
        h = idx_reg - {3'd0, has_colon};
        case (phase_reg)
            PH_OVR:
            begin
                job_done = 1'b1;
            end
            PH_EXT:
            begin
                has_colon = 1'b1;
                has_nl = 1'b1;
                nbytes = 3'd7;
                len_m1 = 4'd15;
                next_ph = PH_HDR;
                job_done = 1'b0;
            end
            PH_HDR:
            begin
                has_colon = 1'b1;
                nbytes = 3'd4;
                len_m1 = 4'd8;
                next_ph = PH_DAT;
                job_done = 1'b0;
            end
            PH_DAT:
            begin
                nbytes = 3'd1;
                len_m1 = 4'd1;
                next_ph = job_reg.trl ? PH_TRL : PH_EOF;
                job_done = !job_reg.trl && !job_reg.eof;
            end
            PH_TRL:
            begin
                has_nl = 1'b1;
                nbytes = 3'd1;
                len_m1 = 4'd2;
                next_ph = PH_EOF;
                job_done = !job_reg.eof;
            end
            PH_EOF:
            begin
                has_colon = 1'b1;
                has_nl = 1'b1;
                nbytes = 3'd5;
                len_m1 = 4'd11;
                job_done = 1'b1;
            end
            default:
            begin
                job_done = 1'b1;
            end
        endcase
        h = idx_reg - {3'd0, has_colon};
        case (phase_reg)
            PH_EXT:
            begin
                case (h[3:1])
                    3'd0: b = ihw_pkg::EXT_LEN;
                    3'd1: b = 8'd0;
                    3'd2: b = 8'd0;
                    3'd3: b = job_reg.ext_seg ? ihw_pkg::REC_SEG : ihw_pkg::REC_LIN;
                    3'd4: b = job_reg.ext_val[15:8];
                    3'd5: b = job_reg.ext_val[7:0];
                    default: b = job_reg.ext_cs;
                endcase
            end
            PH_HDR:
            begin
                case (h[3:1])
                    3'd0: b = job_reg.rec_len;
                    3'd1: b = job_reg.rec_addr[15:8];
                    3'd2: b = job_reg.rec_addr[7:0];
                    default: b = ihw_pkg::REC_DATA;
                endcase
            end
            PH_DAT:
            begin
                b = job_reg.data;
            end
            PH_TRL:
            begin
                b = job_reg.trl_cs;
            end
            PH_EOF:
            begin
                case (h[3:1])
                    3'd3: b = ihw_pkg::REC_EOF;
                    3'd4: b = ihw_pkg::EOF_CS;
                    default: b = 8'd0;
                endcase
            end
            default:
            begin
                b = 8'd0;
            end
        endcase
        phase_last = (idx_reg == len_m1);
        job_done = job_done && phase_last;
        nib = h[0] ? b[3:0] : b[7:4];
        if (phase_reg == PH_OVR)
        begin
            ch = 8'd0;
        end
        else if (has_colon && (idx_reg == 4'd0))
        begin
            ch = ihw_pkg::CHAR_COLON;
        end
        else if (has_nl && (h == {nbytes, 1'b0}))
        begin
            ch = ihw_pkg::CHAR_NEWLINE;
        end
        else
        begin
            ch = hex_digit(nib);
        end
        job_take = job_avail && (!busy_reg || (adv && job_done));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OVR;
            idx_reg <= '0;
            busy_reg <= 1'b0;
            job_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_reg.text_char <= ch;
                out_reg.last_of_run <= job_done;
                out_reg.overrun <= (phase_reg == PH_OVR);
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            if (job_take)
            begin
                job_reg <= job_head;
                phase_reg <= first_phase(job_head);
                idx_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (adv)
            begin
                if (job_done)
                begin
                    busy_reg <= 1'b0;
                end
                else if (phase_last)
                begin
                    phase_reg <= next_ph;
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_writer.sv
// Top level of the Intel HEX record writer: register file, front end, job queue and back end.
// The first character of an item passes the job queue and the back end's job and output registers
// on its way to the result port. The back end sends one character per cycle while jobs are queued
// and the receiver pops; a data byte is two characters, a record header nine, a checksum and newline
// three, an extended address record sixteen and the end-of-file record twelve; the job queue decouples the input.
// Reset clears all control state and loads the register reset values; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_writer #(
    parameter int JOB_DEPTH = ihw_pkg::JOB_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire ihw_pkg::in_t   item,
    output logic                empty,
    input  wire logic           pop,
    output ihw_pkg::out_t       result,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);

    ihw_pkg::cfg_t  cfg_reg;
    ihw_pkg::job_t  front_job;
    ihw_pkg::job_t  head_job;
    logic           accept;
    logic           job_push;
    logic           job_take;
    logic           job_avail;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_row <= ihw_pkg::DEFAULT_ROW;
            cfg_reg.hex_mode <= ihw_pkg::MODE_I8;
            cfg_reg.base_address <= '0;
            cfg_reg.export_length <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ihw_pkg::REG_BYTES_PER_ROW: cfg_reg.bytes_per_row <= cfg_data[7:0];
                ihw_pkg::REG_HEX_MODE:      cfg_reg.hex_mode <= cfg_data[1:0];
                ihw_pkg::REG_BASE_ADDRESS:  cfg_reg.base_address <= cfg_data;
                ihw_pkg::REG_EXPORT_LENGTH: cfg_reg.export_length <= cfg_data;
                default:                    cfg_reg.export_length <= cfg_reg.export_length;
            endcase
        end
    end

    ihw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (front_job)
    );

    ihw_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (front_job),
        .rd_en    (job_take),
        .rd_job   (head_job),
        .full     (full),
        .nonempty (job_avail)
    );

    ihw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job_head  (head_job),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: bench/intel_hex_record_writer_tb.sv
// Self-checking testbench of the Intel HEX record writer: directed and random exports.
`timescale 1ns / 1ps

module intel_hex_record_writer_tb;

    import ihw_pkg::*;

    localparam logic [1:0] MODE_LINEAR = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_BEATS  = 210;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_t         item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_t        result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    in_t  beats_to_send[$];
    out_t expected_text[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic pressure_on = 1'b0;
    int hold_count = 0;

    int error_count = 0;
    int beats_queued = 0;
    int beats_accepted = 0;
    int chars_checked = 0;
    int exports_started = 0;
    int overrun_beats = 0;
    int configs_used = 0;

    logic [7:0]  row_reg = DEFAULT_ROW;
    logic [1:0]  mode_reg = MODE_I8;
    logic [31:0] base_reg = '0;
    logic [31:0] length_reg = '0;

    logic [32:0] next_addr = '0;
    logic [32:0] end_addr = '0;
    logic [7:0]  row_left = '0;
    logic [7:0]  row_sum = '0;
    logic        seg_records = 1'b0;
    logic        export_open = 1'b0;
    logic        first_page = 1'b0;

    intel_hex_record_writer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + nib;
        end
        return CHAR_A + nib - 8'd10;
    endfunction

    function automatic void put_text_char(input logic [7:0] c);
        out_t ch;
        ch.text_char = c;
        ch.last_of_run = 1'b0;
        ch.overrun = 1'b0;
        expected_text.push_back(ch);
    endfunction

    function automatic void put_hex_pair(input logic [7:0] b);
        put_text_char(hex_char(b[7:4]));
        put_text_char(hex_char(b[3:0]));
    endfunction

    function automatic void put_ext_record(input logic [7:0] rec_type, input logic [15:0] value);
        logic [7:0] sum;
        sum = EXT_LEN + rec_type + value[15:8] + value[7:0];
        put_text_char(CHAR_COLON);
        put_hex_pair(EXT_LEN);
        put_hex_pair(8'h00);
        put_hex_pair(8'h00);
        put_hex_pair(rec_type);
        put_hex_pair(value[15:8]);
        put_hex_pair(value[7:0]);
        put_hex_pair(8'h00 - sum);
        put_text_char(CHAR_NEWLINE);
    endfunction

    function automatic void put_eof_record();
        put_text_char(CHAR_COLON);
        put_hex_pair(8'h00);
        put_hex_pair(8'h00);
        put_hex_pair(8'h00);
        put_hex_pair(REC_EOF);
        put_hex_pair(EOF_CS);
        put_text_char(CHAR_NEWLINE);
    endfunction

    // Works out the characters that one accepted beat must produce.
    function automatic void predict_text(input in_t beat);
        logic [33:0] page_end;
        logic [33:0] span;
        logic [7:0]  per_row;
        logic [7:0]  rec_len;
        logic [15:0] rec_addr;
        int          first_new;
        out_t        tail;
        first_new = expected_text.size();
        if (beat.cmd == CMD_START)
        begin
            next_addr = {1'b0, base_reg};
            end_addr = {1'b0, base_reg} + {1'b0, length_reg};
            row_left = '0;
            row_sum = '0;
            seg_records = (mode_reg == MODE_I16) && (length_reg < SEG_LIMIT);
            export_open = (length_reg != 0);
            first_page = export_open;
            exports_started++;
            if (!export_open)
            begin
                put_eof_record();
            end
        end
        else if (!export_open || next_addr >= end_addr)
        begin
            export_open = 1'b0;
            tail.text_char = 8'h00;
            tail.last_of_run = 1'b1;
            tail.overrun = 1'b1;
            expected_text.push_back(tail);
            overrun_beats++;
            return;
        end
        else
        begin
            if (row_left == 0)
            begin
                per_row = (row_reg == 0) ? DEFAULT_ROW : row_reg;
                if (first_page || next_addr[15:0] == 16'h0000)
                begin
                    if (mode_reg != MODE_I8)
                    begin
                        if (seg_records)
                        begin
                            put_ext_record(REC_SEG, next_addr[19:4]);
                        end
                        else
                        begin
                            put_ext_record(REC_LIN, next_addr[31:16]);
                        end
                    end
                    first_page = 1'b0;
                end
                page_end = ({1'b0, next_addr} + PAGE_SIZE) & ~34'h0FFFF;
                if (page_end > {1'b0, end_addr})
                begin
                    page_end = {1'b0, end_addr};
                end
                span = page_end - {1'b0, next_addr};
                rec_len = (span < per_row) ? span[7:0] : per_row;
                rec_addr = next_addr[15:0];
                put_text_char(CHAR_COLON);
                put_hex_pair(rec_len);
                put_hex_pair(rec_addr[15:8]);
                put_hex_pair(rec_addr[7:0]);
                put_hex_pair(REC_DATA);
                row_left = rec_len;
                row_sum = rec_len + rec_addr[15:8] + rec_addr[7:0];
            end
            put_hex_pair(beat.data_byte);
            row_sum = row_sum + beat.data_byte;
            row_left = row_left - 8'd1;
            next_addr = next_addr + 33'd1;
            if (row_left == 0)
            begin
                put_hex_pair(8'h00 - row_sum);
                put_text_char(CHAR_NEWLINE);
            end
            if (next_addr >= end_addr)
            begin
                put_eof_record();
                export_open = 1'b0;
            end
        end
        if (expected_text.size() > first_new)
        begin
            tail = expected_text.pop_back();
            tail.last_of_run = 1'b1;
            expected_text.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_text(item);
                beats_accepted++;
            end
            if (!push || !full)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= beats_to_send.pop_front();
                    push <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected character, expected none, ", $time,
                             "actual char %h last %b ovr %b",
                             result.text_char, result.last_of_run, result.overrun);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (result.text_char !== want.text_char
                        || result.last_of_run !== want.last_of_run
                        || result.overrun !== want.overrun)
                    begin
                        error_count++;
                        $display("%0t: wrong character, expected char %h last %b ovr %b, ",
                                 $time, want.text_char, want.last_of_run, want.overrun,
                                 "actual char %h last %b ovr %b",
                                 result.text_char, result.last_of_run, result.overrun);
                    end
                end
            end
            if (pressure_on && hold_count < LONG_HOLD)
            begin
                hold_count++;
                pop <= 1'b0;
            end
            else
            begin
                if (!pressure_on)
                begin
                    hold_count = 0;
                end
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_BYTES_PER_ROW: row_reg = value[7:0];
            REG_HEX_MODE:      mode_reg = value[1:0];
            REG_BASE_ADDRESS:  base_reg = value;
            default:           length_reg = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] row, input logic [1:0] mode,
                             input logic [31:0] base, input logic [31:0] len);
        write_reg(REG_BYTES_PER_ROW, {24'h0, row});
        write_reg(REG_HEX_MODE, {30'h0, mode});
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_EXPORT_LENGTH, len);
        configs_used++;
    endtask

    task automatic set_idling(input int pattern);
        @(negedge clk);
        case (pattern % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 69;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 69;
            end
            default:
            begin
                send_idle_pct = 7;
                recv_stall_pct = 7;
            end
        endcase
    endtask

    task automatic queue_beat(input logic cmd, input logic [7:0] data);
        in_t b;
        b.cmd = cmd;
        b.data_byte = data;
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (beats_to_send.size() != 0 || push || expected_text.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_export(input int pattern);
        logic [7:0]  row;
        logic [1:0]  mode;
        logic [31:0] base;
        logic [31:0] len;
        int          n_bytes;
        int          shape;
        int          restart_at;
        case ($urandom_range(9))
            0:       row = 8'd0;
            1:       row = 8'd255;
            2:       row = 8'($urandom_range(255));
            default: row = 8'($urandom_range(1, 8));
        endcase
        mode = 2'($urandom_range(3));
        case ($urandom_range(7))
            0:       base = 32'd0;
            1:       base = 32'hFFFFFFFF - $urandom_range(40);
            2:       base = ($urandom & 32'hFFFF0000) | (32'h0000FFFF - $urandom_range(30));
            3:       base = $urandom_range(40);
            default: base = $urandom;
        endcase
        case ($urandom_range(11))
            0:       len = 32'd0;
            1:       len = $urandom;
            2:       len = 32'hFFFFFFFF;
            3:       len = SEG_LIMIT - 32'd1 + $urandom_range(1);
            default: len = $urandom_range(1, 24);
        endcase
        configure(row, mode, base, len);
        set_idling(pattern);
        n_bytes = (len > 40) ? $urandom_range(1, 40) : len;
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            n_bytes = $urandom_range(n_bytes);
        end
        restart_at = (shape == 2) ? $urandom_range(n_bytes) : -1;
        if (shape == 3)
        begin
            queue_beat(CMD_DATA, 8'($urandom_range(255)));
        end
        queue_beat(CMD_START, 8'($urandom_range(255)));
        for (int i = 0; i < n_bytes; i++)
        begin
            if (i == restart_at)
            begin
                queue_beat(CMD_START, 8'($urandom_range(255)));
            end
            queue_beat(CMD_DATA, 8'($urandom_range(255)));
        end
        if (shape == 1)
        begin
            repeat ($urandom_range(1, 3)) queue_beat(CMD_DATA, 8'($urandom_range(255)));
        end
        wait_idle();
    endtask

    initial
    begin
        int pattern;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Beats before any export, then an empty export.
        set_idling(0);
        queue_beat(CMD_DATA, 8'hFF);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h00);
        wait_idle();

        // Single-byte rows across a page boundary with segment records.
        configure(8'd1, MODE_I16, 32'h0000FFFE, 32'd3);
        set_idling(0);
        queue_beat(CMD_START, 8'hFF);
        queue_beat(CMD_DATA, 8'h00);
        queue_beat(CMD_DATA, 8'hFF);
        queue_beat(CMD_DATA, 8'hA5);
        queue_beat(CMD_DATA, 8'h5A);
        wait_idle();

        // Address wrap at the top of the 32-bit space with linear records.
        configure(8'd0, MODE_LINEAR, 32'hFFFFFFFF, 32'd2);
        set_idling(0);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h12);
        queue_beat(CMD_DATA, 8'h34);
        wait_idle();

        // Length at the segment limit falls back to linear; restart mid-export.
        configure(8'd255, MODE_I16, 32'h00012345, SEG_LIMIT);
        set_idling(0);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h3C);
        queue_beat(CMD_DATA, 8'hC3);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h81);
        wait_idle();

        configure(8'd255, MODE_I16, 32'h000FFFFE, SEG_LIMIT - 32'd1);
        set_idling(0);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h01);
        queue_beat(CMD_DATA, 8'h02);
        queue_beat(CMD_DATA, 8'h03);
        wait_idle();

        configure(8'd7, MODE_SPARE, 32'h00000000, 32'hFFFFFFFF);
        set_idling(0);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_DATA, 8'h7E);
        queue_beat(CMD_DATA, 8'hE7);
        wait_idle();

        // The receiver holds off while the sender keeps offering beats.
        configure(8'd16, MODE_LINEAR, 32'h0001FFF0, 32'd64);
        set_idling(0);
        pressure_on = 1'b1;
        queue_beat(CMD_START, 8'h00);
        for (int i = 0; i < 64; i++)
        begin
            queue_beat(CMD_DATA, 8'($urandom_range(255)));
        end
        wait_idle();
        @(negedge clk);
        pressure_on = 1'b0;

        pattern = 0;
        while (beats_queued < RANDOM_BEATS + 90)
        begin
            random_export(pattern);
            pattern++;
        end

        wait_idle();
        $display("Run covered %0d beats in %0d exports under %0d register settings, ",
                 beats_accepted, exports_started, configs_used,
                 "%0d overruns.", overrun_beats);
        $display("Checked %0d text characters with all idling patterns and one long hold-off.",
                 chars_checked);
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the block.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/ihw_pkg.sv
rtl/ihw_front.sv
rtl/ihw_job_fifo.sv
rtl/ihw_back.sv
rtl/intel_hex_record_writer.sv
bench/intel_hex_record_writer_tb.sv
